[sv/itf_pkg.sv]
// Package for the IMU complementary tilt filter: beat payload structs,
// fixed widths, arctangent table and saturation helper. No dependencies.
package itf_pkg;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic        [15:0] elapsed_ms;
	} in_t;

	typedef struct packed {
		logic signed [31:0] angle_x;
		logic signed [31:0] angle_y;
		logic signed [31:0] angle_z;
		logic signed [31:0] drift_x;
		logic signed [31:0] drift_y;
		logic signed [31:0] drift_z;
	} out_t;

	// register indexes
	localparam logic [2:0] REG_ACC_OFF_X = 3'd0;
	localparam logic [2:0] REG_ACC_OFF_Y = 3'd1;
	localparam logic [2:0] REG_ACC_OFF_Z = 3'd2;
	localparam logic [2:0] REG_RATE_OFF_X = 3'd3;
	localparam logic [2:0] REG_RATE_OFF_Y = 3'd4;
	localparam logic [2:0] REG_RATE_OFF_Z = 3'd5;
	localparam logic [2:0] REG_SENS = 3'd6;
	localparam logic [2:0] REG_BLEND = 3'd7;

	localparam logic [15:0] SENS_RESET = 16'd131;
	localparam logic [15:0] BLEND_RESET = 16'd62915;

	localparam int DIV_DW = 48;	// dividend width
	localparam int DIV_VW = 26;	// divisor width

	// atan(2^-i) in Q16.16 degrees
	function automatic logic [21:0] atan_q16(input logic [4:0] i);
		logic [21:0] v;
		unique case (i)
			5'd0: v = 22'd2949120;
			5'd1: v = 22'd1740967;
			5'd2: v = 22'd919879;
			5'd3: v = 22'd466945;
			5'd4: v = 22'd234379;
			5'd5: v = 22'd117304;
			5'd6: v = 22'd58666;
			5'd7: v = 22'd29335;
			5'd8: v = 22'd14668;
			5'd9: v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
		logic signed [31:0] r;
		if (v > 44'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -44'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

[sv/itf_div.sv]
// Restoring serial divider, one quotient bit per cycle, unsigned.
// Uses itf_pkg for operand widths.
module itf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [itf_pkg::DIV_DW-1:0]    dividend,
	input  logic [itf_pkg::DIV_VW-1:0]    divisor,
	output logic [itf_pkg::DIV_DW-1:0]    quot,
	output logic                          done
);
	localparam int DW = itf_pkg::DIV_DW;
	localparam int VW = itf_pkg::DIV_VW;

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          ge;

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign quot = quo_q;
	assign done = done_q;
endmodule

[sv/imu_complementary_tilt_filter_unit.sv]
// IMU complementary tilt filter: offsets, gyro integration, CORDIC tilt, blend.
// Depends on itf_pkg and itf_div.
//
// One sample beat is taken only while the block is idle and yields one result beat.
// An all-zero accel vector skips both CORDIC passes. Per tilt axis: two squares,
// a 25-step square root and the CORDIC iterations; per gyro axis a multiply,
// a 48-step serial divide and the blend multiply-accumulate steps,
// all through one shared 18x26 multiplier.
// A new sample may be taken while the previous result still waits on out_ready.
module imu_complementary_tilt_filter_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  itf_pkg::in_t    in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output itf_pkg::out_t   out_data,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [15:0]     cfg_wdata
);
	localparam int NST = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam int CW  = (NST > 1) ? $clog2(NST) : 1;

	typedef enum logic [14:0] {
		S_IDLE   = 15'h0001,
		S_SQA    = 15'h0002,
		S_SQB    = 15'h0004,
		S_SQC    = 15'h0008,
		S_SQRT   = 15'h0010,
		S_CINIT  = 15'h0020,
		S_CORD   = 15'h0040,
		S_RMUL   = 15'h0080,
		S_DSTART = 15'h0100,
		S_DWAIT  = 15'h0200,
		S_BL1    = 15'h0400,
		S_BL2    = 15'h0800,
		S_BL3    = 15'h1000,
		S_BL4    = 15'h2000,
		S_DONE   = 15'h4000
	} state_t;

	state_t state_q;

	logic signed [15:0] acc_off_q [3];
	logic signed [15:0] rate_off_q [3];
	logic [15:0]        sens_q;
	logic [15:0]        blend_q;

	logic signed [16:0] a_q [3];
	logic signed [16:0] r_q [3];
	logic [15:0]        ms_q;

	logic signed [31:0] filt_q [3];
	logic signed [31:0] drift_q [3];
	logic signed [23:0] tilt_q [2];

	logic               tsel_q;
	logic [1:0]         ax_q;

	logic [33:0]        sq_q;
	logic [49:0]        n_q, res_q, bit_q;
	logic [4:0]         sqrt_cnt_q;

	logic signed [27:0] x_q, y_q;
	logic signed [25:0] z_q;
	logic [CW-1:0]      ci_q;

	logic signed [43:0] prod_q;
	logic signed [43:0] lo_q;
	logic signed [39:0] inc_q;
	logic signed [40:0] g_q;

	itf_pkg::out_t      out_q;
	logic               out_valid_q;

	// shared multiplier
	logic signed [17:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [43:0] mul_p;

	logic signed [16:0] num_v, av_v, bv_v;
	logic [16:0]        mag_v;
	logic signed [23:0] acc_v;

	always_comb begin
		num_v = tsel_q ? a_q[0] : a_q[1];
		av_v  = tsel_q ? a_q[1] : a_q[0];
		bv_v  = a_q[2];
		mag_v = r_q[ax_q][16] ? 17'(-r_q[ax_q]) : 17'(r_q[ax_q]);
		acc_v = (ax_q == 2'd2) ? 24'sd0 : tilt_q[ax_q[0]];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQA: begin
				mul_a = 18'(av_v);
				mul_b = 26'(av_v);
			end
			S_SQB: begin
				mul_a = 18'(bv_v);
				mul_b = 26'(bv_v);
			end
			S_RMUL: begin
				mul_a = $signed({1'b0, mag_v});
				mul_b = $signed({10'd0, ms_q});
			end
			S_BL1: begin
				mul_a = $signed({2'b00, blend_q});
				mul_b = $signed({10'd0, g_q[15:0]});
			end
			S_BL2: begin
				mul_a = $signed(18'd65536 - {2'b00, blend_q});
				mul_b = 26'(acc_v);
			end
			S_BL3: begin
				mul_a = $signed({2'b00, blend_q});
				mul_b = 26'($signed(g_q[40:16]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// square root step
	logic [49:0] sq_cmp;
	assign sq_cmp = res_q + bit_q;

	// CORDIC step
	logic signed [27:0] dx, dy, x_n, y_n;
	logic signed [25:0] z_n, at_v;
	always_comb begin
		dx   = y_q >>> ci_q;
		dy   = x_q >>> ci_q;
		at_v = $signed({4'd0, itf_pkg::atan_q16(5'(ci_q))});
		if (y_q > 28'sd0) begin
			x_n = x_q + dx;
			y_n = y_q - dy;
			z_n = z_q + at_v;
		end else begin
			x_n = x_q - dx;
			y_n = y_q + dy;
			z_n = z_q - at_v;
		end
	end

	// divider: (|r| * ms << 16) / (1000 * sens)
	logic [15:0]                  sens_eff;
	logic [itf_pkg::DIV_VW-1:0]   den;
	logic [itf_pkg::DIV_DW-1:0]   quot;
	logic                         div_done;

	assign sens_eff = (sens_q == 16'd0) ? 16'd1 : sens_q;
	assign den = (26'(sens_eff) << 10) - (26'(sens_eff) << 4) - (26'(sens_eff) << 3);

	itf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DSTART),
		.dividend ({prod_q[31:0], 16'd0}),
		.divisor  (den),
		.quot     (quot),
		.done     (div_done)
	);

	logic signed [39:0] inc_v;
	assign inc_v = r_q[ax_q][16] ? -$signed({1'b0, quot[38:0]}) : $signed({1'b0, quot[38:0]});

	logic signed [43:0] blend_res;
	logic signed [43:0] drift_sum;
	assign blend_res = prod_q + (lo_q >>> 16);
	assign drift_sum = 44'(drift_q[ax_q]) + 44'(inc_q);

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			tsel_q      <= 1'b0;
			ax_q        <= '0;
			sqrt_cnt_q  <= '0;
			ci_q        <= '0;
			sens_q      <= itf_pkg::SENS_RESET;
			blend_q     <= itf_pkg::BLEND_RESET;
			for (int k = 0; k < 3; k++) begin
				acc_off_q[k]  <= '0;
				rate_off_q[k] <= '0;
				filt_q[k]     <= '0;
				drift_q[k]    <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					itf_pkg::REG_ACC_OFF_X:  acc_off_q[0] <= cfg_wdata;
					itf_pkg::REG_ACC_OFF_Y:  acc_off_q[1] <= cfg_wdata;
					itf_pkg::REG_ACC_OFF_Z:  acc_off_q[2] <= cfg_wdata;
					itf_pkg::REG_RATE_OFF_X: rate_off_q[0] <= cfg_wdata;
					itf_pkg::REG_RATE_OFF_Y: rate_off_q[1] <= cfg_wdata;
					itf_pkg::REG_RATE_OFF_Z: rate_off_q[2] <= cfg_wdata;
					itf_pkg::REG_SENS:       sens_q <= cfg_wdata;
					itf_pkg::REG_BLEND:      blend_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (state_q == S_DONE && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						tsel_q  <= 1'b0;
						state_q <= S_SQA;
					end
				end
				S_SQA:  state_q <= S_SQB;
				S_SQB:  state_q <= S_SQC;
				S_SQC: begin
					sqrt_cnt_q <= '0;
					state_q    <= S_SQRT;
				end
				S_SQRT: begin
					sqrt_cnt_q <= sqrt_cnt_q + 5'd1;
					if (sqrt_cnt_q == 5'd24)
						state_q <= S_CINIT;
				end
				S_CINIT: begin
					ci_q <= '0;
					if (res_q == 50'd0 && num_v == 17'sd0) begin
						// atan2(0, 0) taken as zero
						tilt_q[tsel_q] <= '0;
						if (tsel_q) begin
							ax_q    <= '0;
							state_q <= S_RMUL;
						end else begin
							tsel_q  <= 1'b1;
							state_q <= S_SQA;
						end
					end else begin
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					ci_q <= ci_q + CW'(1);
					if (ci_q == CW'(NST - 1)) begin
						tilt_q[tsel_q] <= z_n[23:0];
						if (tsel_q) begin
							ax_q    <= '0;
							state_q <= S_RMUL;
						end else begin
							tsel_q  <= 1'b1;
							state_q <= S_SQA;
						end
					end
				end
				S_RMUL:   state_q <= S_DSTART;
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_done)
						state_q <= S_BL1;
				end
				S_BL1: state_q <= S_BL2;
				S_BL2: state_q <= S_BL3;
				S_BL3: state_q <= S_BL4;
				S_BL4: begin
					filt_q[ax_q]  <= itf_pkg::sat32(blend_res);
					drift_q[ax_q] <= itf_pkg::sat32(drift_sum);
					if (ax_q == 2'd2) begin
						state_q <= S_DONE;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_RMUL;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (state_q == S_IDLE && in_valid) begin
			a_q[0] <= 17'(in_data.accel_x) - 17'(acc_off_q[0]);
			a_q[1] <= 17'(in_data.accel_y) - 17'(acc_off_q[1]);
			a_q[2] <= 17'(in_data.accel_z) - 17'(acc_off_q[2]);
			r_q[0] <= 17'(in_data.rate_x) - 17'(rate_off_q[0]);
			r_q[1] <= 17'(in_data.rate_y) - 17'(rate_off_q[1]);
			r_q[2] <= 17'(in_data.rate_z) - 17'(rate_off_q[2]);
			ms_q   <= in_data.elapsed_ms;
		end
		if (state_q == S_SQB)
			sq_q <= prod_q[33:0];
		if (state_q == S_SQC) begin
			n_q   <= {sq_q + prod_q[33:0], 16'd0};
			res_q <= '0;
			bit_q <= 50'd1 << 48;
		end
		if (state_q == S_SQRT) begin
			if (n_q >= sq_cmp) begin
				n_q   <= n_q - sq_cmp;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (state_q == S_CINIT) begin
			x_q <= $signed({2'b00, res_q[25:0]});
			y_q <= 28'($signed({num_v, 8'd0}));
			z_q <= '0;
		end
		if (state_q == S_CORD) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
		if (state_q == S_DWAIT && div_done) begin
			inc_q <= inc_v;
			g_q   <= 41'(filt_q[ax_q]) + 41'(inc_v);
		end
		if (state_q == S_BL2)
			lo_q <= prod_q + 44'sd32768;
		if (state_q == S_BL3)
			lo_q <= lo_q + prod_q;
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_q.angle_x <= filt_q[0];
			out_q.angle_y <= filt_q[1];
			out_q.angle_z <= filt_q[2];
			out_q.drift_x <= drift_q[0];
			out_q.drift_y <= drift_q[1];
			out_q.drift_z <= drift_q[2];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
